/* rtl/bgc_pkg.sv */
package bgc_pkg;

	localparam int TICK_W   = 32;
	localparam int PERIOD_W = 10;
	localparam int MS_W     = 16;
	localparam int PROD_W   = TICK_W + PERIOD_W;

	localparam int CFG_DATA_W = MS_W;
	localparam int CFG_IDX_W  = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW  = 2'd2;

	localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 10'd1;
	localparam logic [MS_W-1:0]     LONG_PRESS_RST  = 16'd2000;
	localparam logic [MS_W-1:0]     DBL_WINDOW_RST  = 16'd750;

	// request types
	localparam logic REQ_POLL  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// phase codes
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PRESSED = 2'd1;
	localparam logic [1:0] PH_WAIT    = 2'd2;
	localparam logic [1:0] PH_LONG    = 2'd3;

	// event codes
	localparam logic [1:0] EV_NONE   = 2'd0;
	localparam logic [1:0] EV_SINGLE = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_LONG   = 2'd3;

endpackage

/* rtl/button_gesture_classifier.sv */
// channel | handshake              | payload
// --------+------------------------+------------------------------
// in      | in_valid / in_stall    | req_type, pressed, now_tick
// out     | out_valid / out_stall  | event_code, phase
// cfg     | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// One transaction per cycle while the result is not stalled; a result passes through the input register,
// then the result register.
// The elapsed-tick multiply and window compare sit between those two registers.
// arst_n clears the phase machine, timestamps, latched event and loads register defaults.
// A stalled result holds; the input register still fills, and in_stall rises only
// when both the input and result registers are full.
module button_gesture_classifier
	import bgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic                  pressed,
	input  logic [31:0]           now_tick,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            event_code,
	output logic [1:0]            phase
);

	logic [PERIOD_W-1:0] tick_period_q;
	logic [MS_W-1:0]     long_press_q;
	logic [MS_W-1:0]     dbl_window_q;

	logic                valid_s1;
	logic                req_type_s1;
	logic                pressed_s1;
	logic [TICK_W-1:0]   now_s1;

	logic                valid_s2;
	logic [1:0]          event_code_s2;
	logic [1:0]          phase_s2;

	logic [1:0]          phase_q;
	logic [TICK_W-1:0]   press_time_q;
	logic [TICK_W-1:0]   release_time_q;
	logic                long_fired_q;
	logic [1:0]          pending_q;

	logic                advance;
	logic                fire_s1;
	logic [TICK_W-1:0]   elapsed;
	logic [PROD_W-1:0]   product;
	logic [MS_W-1:0]     limit;
	logic                passed;

	logic [1:0]          code_nx;
	logic [1:0]          phase_nx;
	logic [1:0]          pending_nx;
	logic                long_fired_nx;
	logic                set_press;
	logic                set_release;

	assign advance  = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= TICK_PERIOD_RST;
			long_press_q  <= LONG_PRESS_RST;
			dbl_window_q  <= DBL_WINDOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_TICK_PERIOD: tick_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_LONG_PRESS:  long_press_q  <= cfg_data[MS_W-1:0];
				CFG_DBL_WINDOW:  dbl_window_q  <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			pressed_s1  <= pressed;
			now_s1      <= TICK_W'(now_tick);
		end
	end

	// elapsed ticks scaled to ms at full width, compared strictly against the window
	always_comb begin
		elapsed = now_s1 - ((phase_q == PH_PRESSED) ? press_time_q : release_time_q);
		product = PROD_W'(elapsed) * PROD_W'(tick_period_q);
		limit   = (phase_q == PH_PRESSED) ? long_press_q : dbl_window_q;
		passed  = product > PROD_W'(limit);
	end

	always_comb begin
		code_nx       = EV_NONE;
		phase_nx      = phase_q;
		pending_nx    = pending_q;
		long_fired_nx = long_fired_q;
		set_press     = 1'b0;
		set_release   = 1'b0;
		if (req_type_s1 == REQ_FETCH) begin
			code_nx    = pending_q;
			pending_nx = EV_NONE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (pressed_s1) begin
						phase_nx      = PH_PRESSED;
						set_press     = 1'b1;
						long_fired_nx = 1'b0;
					end
				end
				PH_PRESSED: begin
					if (!pressed_s1) begin
						phase_nx    = PH_WAIT;
						set_release = 1'b1;
					end else if (!long_fired_q && passed) begin
						phase_nx      = PH_LONG;
						pending_nx    = EV_LONG;
						long_fired_nx = 1'b1;
					end
				end
				PH_WAIT: begin
					if (pressed_s1) begin
						phase_nx   = PH_IDLE;
						pending_nx = EV_DOUBLE;
					end else if (passed) begin
						phase_nx   = PH_IDLE;
						pending_nx = EV_SINGLE;
					end
				end
				PH_LONG: begin
					if (!pressed_s1) begin
						phase_nx = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			press_time_q   <= '0;
			release_time_q <= '0;
			long_fired_q   <= 1'b0;
			pending_q      <= EV_NONE;
		end else if (fire_s1) begin
			phase_q      <= phase_nx;
			long_fired_q <= long_fired_nx;
			pending_q    <= pending_nx;
			if (set_press) begin
				press_time_q <= now_s1;
			end
			if (set_release) begin
				release_time_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			event_code_s2 <= code_nx;
			phase_s2      <= phase_nx;
		end
	end

	assign out_valid  = valid_s2;
	assign event_code = event_code_s2;
	assign phase      = phase_s2;

endmodule

/* rtl/bgc_checker.sv */
module bgc_checker
	import bgc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [1:0]            event_code,
	input logic [1:0]            phase
);

	// input side backs up only when the result register is full and stalled
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall raised while result register can drain");

	// a fresh result follows an accepted transaction through the input and result registers
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching input transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_code) && $stable(phase)))
		else $error("stalled result changed or dropped");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (.*);

/* tb/gesture_checker.sv */
`timescale 1ns / 100ps

module gesture_checker
	import bgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  req_type,
	input  logic                  pressed,
	input  logic [31:0]           now_tick,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [1:0]            event_code,
	input  logic [1:0]            phase,
	output int                    pending,
	output int                    errors
);

	typedef struct packed {
		logic [1:0] code;
		logic [1:0] ph;
	} gesture_result_t;

	gesture_result_t gesture_q[$];

	logic [PERIOD_W-1:0] period;
	logic [MS_W-1:0]     long_ms;
	logic [MS_W-1:0]     dbl_ms;

	logic [1:0]  ph_q;
	logic [31:0] press_t;
	logic [31:0] release_t;
	logic        long_done;
	logic [1:0]  latched;

	// elapsed ticks times period against the limit, at full width
	function automatic logic window_over(input logic [31:0] now, input logic [31:0] since,
			input logic [MS_W-1:0] limit);
		logic [31:0]     elapsed;
		logic [PROD_W-1:0] prod;
		elapsed = now - since;
		prod = PROD_W'(elapsed) * PROD_W'(period);
		return prod > PROD_W'(limit);
	endfunction

	task automatic classify_sample(input logic rq, input logic down, input logic [31:0] now);
		gesture_result_t r;
		r.code = EV_NONE;
		if (rq == REQ_FETCH) begin
			r.code = latched;
			latched = EV_NONE;
		end else begin
			case (ph_q)
				PH_IDLE: begin
					if (down) begin
						ph_q = PH_PRESSED;
						press_t = now;
						long_done = 1'b0;
					end
				end
				PH_PRESSED: begin
					if (!down) begin
						release_t = now;
						ph_q = PH_WAIT;
					end else if (!long_done && window_over(now, press_t, long_ms)) begin
						latched = EV_LONG;
						long_done = 1'b1;
						ph_q = PH_LONG;
					end
				end
				PH_WAIT: begin
					if (down) begin
						ph_q = PH_IDLE;
						latched = EV_DOUBLE;
					end else if (window_over(now, release_t, dbl_ms)) begin
						ph_q = PH_IDLE;
						latched = EV_SINGLE;
					end
				end
				default: begin
					if (!down)
						ph_q = PH_IDLE;
				end
			endcase
		end
		r.ph = ph_q;
		gesture_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		gesture_result_t want;
		if (!arst_n) begin
			gesture_q.delete();
			period = TICK_PERIOD_RST;
			long_ms = LONG_PRESS_RST;
			dbl_ms = DBL_WINDOW_RST;
			ph_q = PH_IDLE;
			press_t = '0;
			release_t = '0;
			long_done = 1'b0;
			latched = EV_NONE;
			errors = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TICK_PERIOD: period = cfg_data[PERIOD_W-1:0];
					CFG_LONG_PRESS:  long_ms = cfg_data;
					CFG_DBL_WINDOW:  dbl_ms = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (gesture_q.size() == 0) begin
					$display("%0t: unexpected result, event_code %0d phase %0d",
						$time, event_code, phase);
					errors++;
				end else begin
					want = gesture_q.pop_front();
					if (event_code !== want.code) begin
						$display("%0t: event_code expected %0d actual %0d",
							$time, want.code, event_code);
						errors++;
					end
					if (phase !== want.ph) begin
						$display("%0t: phase expected %0d actual %0d",
							$time, want.ph, phase);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				classify_sample(req_type, pressed, now_tick);
		end
		pending = gesture_q.size();
	end

endmodule

/* tb/tb_button_gesture_classifier.sv */
`timescale 1ns / 100ps

module tb_button_gesture_classifier;
	import bgc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int SQUEEZE_CYCLES = 80;
	localparam int PHASE_ITEMS = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = REQ_POLL;
	logic        pressed = 1'b0;
	logic [31:0] now_tick = '0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] event_code;
	logic [1:0] phase;

	int pending;
	int errors;

	int          items_sent = 0;
	int          squeeze_reqs = 0;
	int          quiet = 0;
	logic        calm = 1'b0;
	logic [31:0] tick = '0;

	logic [PERIOD_W-1:0] cfg_period = TICK_PERIOD_RST;
	logic [MS_W-1:0]     cfg_long = LONG_PRESS_RST;
	logic [MS_W-1:0]     cfg_dbl = DBL_WINDOW_RST;

	always #2 clk = ~clk;

	button_gesture_classifier dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.pressed    (pressed),
		.now_tick   (now_tick),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.phase      (phase)
	);

	gesture_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.pressed    (pressed),
		.now_tick   (now_tick),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.phase      (phase),
		.pending    (pending),
		.errors     (errors)
	);

	// receiver: random stalls (none while calm), plus a long hold-off on request
	initial begin : receiver
		int hold_left;
		int squeeze_seen;
		hold_left = 0;
		squeeze_seen = 0;
		forever begin
			@(posedge clk);
			if (squeeze_reqs != squeeze_seen) begin
				squeeze_seen = squeeze_reqs;
				hold_left = SQUEEZE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 37);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("button_gesture_classifier verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic rq, input logic down, input logic [31:0] t);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		pressed <= down;
		now_tick <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// poll, sometimes preceded by a fetch of the latched event
	task automatic poll_at(input logic down, input logic [31:0] t);
		if ($urandom_range(0, 99) < 15)
			send_item(REQ_FETCH, 1'($urandom_range(0, 1)), $urandom());
		send_item(REQ_POLL, down, t);
		tick = t;
	endtask

	function automatic longint tick_threshold(input logic [MS_W-1:0] limit_ms);
		if (cfg_period == '0)
			return $urandom_range(0, 3000);
		return limit_ms / cfg_period;
	endfunction

	// span in ticks, mostly on or near the edge of a window, sometimes anywhere below it
	function automatic longint pick_span(input longint thr);
		case ($urandom_range(0, 4))
			0: return (thr > 0) ? thr - 1 : 0;
			1: return thr;
			2: return thr + 1;
			3: return thr + $urandom_range(2, 40);
			default: return $urandom_range(0, 32'(thr));
		endcase
	endfunction

	task automatic press_gesture();
		longint      hold;
		longint      gap;
		logic [31:0] t0;
		logic [31:0] t_rel;
		int          steps;
		hold = pick_span(tick_threshold(cfg_long));
		gap = pick_span(tick_threshold(cfg_dbl));
		if ($urandom_range(0, 4) == 0)
			tick = 32'hFFFF_FFFF - $urandom_range(0, 300);
		t0 = tick + $urandom_range(1, 20);
		poll_at(1'b1, t0);
		steps = $urandom_range(0, 3);
		for (int k = 1; k <= steps; k++)
			poll_at(1'b1, t0 + 32'(hold * k / (steps + 1)));
		poll_at(1'b1, t0 + 32'(hold));
		if ($urandom_range(0, 1))
			poll_at(1'b1, tick + $urandom_range(0, 5));
		t_rel = tick + $urandom_range(0, 3);
		poll_at(1'b0, t_rel);
		// leave the wait phase open for the next gesture to resolve
		if ($urandom_range(0, 3) == 0)
			return;
		steps = $urandom_range(0, 2);
		for (int k = 1; k <= steps; k++)
			poll_at(1'b0, t_rel + 32'(gap * k / (steps + 1)));
		if ($urandom_range(0, 1)) begin
			poll_at(1'b1, t_rel + 32'(gap));
			poll_at(1'b0, tick + $urandom_range(1, 10));
		end else begin
			poll_at(1'b0, t_rel + 32'(gap));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [PERIOD_W-1:0] tp, input logic [MS_W-1:0] lp,
			input logic [MS_W-1:0] dw);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TICK_PERIOD;
		cfg_data <= {6'($urandom()), tp};
		@(posedge clk);
		cfg_index <= CFG_LONG_PRESS;
		cfg_data <= lp;
		@(posedge clk);
		cfg_index <= CFG_DBL_WINDOW;
		cfg_data <= dw;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= 16'($urandom());
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_period = tp;
		cfg_long = lp;
		cfg_dbl = dw;
	endtask

	task automatic run_phase(input int n);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			if ($urandom_range(0, 99) < 15)
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
			else
				press_gesture();
		end
		settle();
	endtask

	// runs with reset register values
	task automatic directed_items();
		send_item(REQ_FETCH, 1'b1, 32'hFFFF_FFFF);
		send_item(REQ_POLL, 1'b0, 32'h0);
		// long press across the tick wrap: fires one tick past the limit
		send_item(REQ_POLL, 1'b1, 32'hFFFF_FFF0);
		send_item(REQ_POLL, 1'b1, 32'h0000_07C0);
		send_item(REQ_POLL, 1'b1, 32'h0000_07C1);
		send_item(REQ_POLL, 1'b1, 32'h0000_9000);
		send_item(REQ_FETCH, 1'b0, 32'h0);
		send_item(REQ_FETCH, 1'b0, 32'h0);
		send_item(REQ_POLL, 1'b0, 32'h0000_9001);
		// single press, window expires one tick past its limit
		send_item(REQ_POLL, 1'b1, 32'd100);
		send_item(REQ_POLL, 1'b0, 32'd200);
		send_item(REQ_POLL, 1'b0, 32'd950);
		send_item(REQ_POLL, 1'b0, 32'd951);
		send_item(REQ_FETCH, 1'b1, 32'd0);
		// double press right at the window edge
		send_item(REQ_POLL, 1'b1, 32'd1000);
		send_item(REQ_POLL, 1'b0, 32'd1100);
		send_item(REQ_POLL, 1'b1, 32'd1850);
		send_item(REQ_POLL, 1'b0, 32'd1900);
		// single overwrites the unfetched double, release across the wrap
		send_item(REQ_POLL, 1'b1, 32'hFFFF_FFFF);
		send_item(REQ_POLL, 1'b0, 32'h0);
		send_item(REQ_POLL, 1'b0, 32'd751);
		send_item(REQ_FETCH, 1'b0, 32'hFFFF_FFFF);
		send_item(REQ_FETCH, 1'b0, 32'h0);
		tick = 32'd2000;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		run_phase(PHASE_ITEMS);
		program_regs(10'd1, 16'd1, 16'd1);
		run_phase(PHASE_ITEMS);
		program_regs(10'd1000, 16'hFFFF, 16'hFFFF);
		squeeze_reqs++;
		run_phase(PHASE_ITEMS);
		program_regs(10'd0, 16'd2000, 16'd750);
		run_phase(PHASE_ITEMS);
		calm = 1'b1;
		program_regs(10'd1, 16'hFFFF, 16'hFFFF);
		run_phase(PHASE_ITEMS);
		calm = 1'b0;
		program_regs(10'd1023, 16'd1, 16'hFFFF);
		run_phase(PHASE_ITEMS);
		repeat (2) begin
			program_regs(10'($urandom_range(1, 1000)), 16'($urandom_range(1, 65535)),
				16'($urandom_range(1, 65535)));
			run_phase(PHASE_ITEMS);
		end
		if (errors == 0)
			$display("button_gesture_classifier verification clean");
		else
			$display("button_gesture_classifier verification failed");
		$finish;
	end

endmodule
